// File: rtl/mnmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnmc_pkg
// Shared constants, types and the read-symbol decode for the masked
// nucleotide mismatch counter.
// ----------------------------------------------------------------------------
package mnmc_pkg;

  localparam int unsigned LANES    = 8;
  localparam int unsigned LaneIdxW = 3;
  localparam int unsigned MaskW    = 4;
  localparam int unsigned SymW     = 3;
  localparam int unsigned RefW     = LANES * MaskW;
  localparam int unsigned SeqW     = LANES * SymW;
  localparam int unsigned CountW   = 10;
  localparam int unsigned AddW     = $clog2(LANES + 1);
  localparam int unsigned SumW     = CountW + 1;
  localparam int unsigned PaddrW   = 3;
  localparam int unsigned PdataW   = 32;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Symbol codes of a read base; anything above the last base counts as N.
  localparam logic [SymW-1:0]  SymBaseLast = 3'd3;
  localparam logic [MaskW-1:0] CodeAny     = 4'hF;

  // Register indexes of the configuration port.
  localparam logic [0:0] RegMaxErrors = 1'b0;

  // Control that travels with an item from the lane stage to the merge stage.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } stage_ctrl_t;

  // Decode a read symbol into its nucleotide mask.
  function automatic logic [MaskW-1:0] read_code(input logic [SymW-1:0] sym);
    logic [MaskW-1:0] code;
    if (sym > SymBaseLast) begin
      code = CodeAny;
    end else begin
      code = MaskW'(1) << sym[1:0];
    end
    return code;
  endfunction

endpackage

// File: rtl/mnmc_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnmc_req_if
// Request channel: one reference word, its read symbols and lane range.
// ----------------------------------------------------------------------------
interface mnmc_req_if;
  logic                           valid;
  logic                           ready;
  logic [mnmc_pkg::RefW-1:0]      ref_word;
  logic [mnmc_pkg::SeqW-1:0]      seq_symbols;
  logic [mnmc_pkg::LaneIdxW-1:0]  lane_lo;
  logic [mnmc_pkg::LaneIdxW-1:0]  lane_hi;
  logic                           first_word;
  logic                           last_word;

  modport source (
    output valid, ref_word, seq_symbols, lane_lo, lane_hi, first_word, last_word,
    input  ready
  );

  modport sink (
    input  valid, ref_word, seq_symbols, lane_lo, lane_hi, first_word, last_word,
    output ready
  );
endinterface

// File: rtl/mnmc_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnmc_res_if
// Result channel: mismatch count and over-limit flag of one comparison.
// ----------------------------------------------------------------------------
interface mnmc_res_if;
  logic                         valid;
  logic                         ready;
  logic [mnmc_pkg::CountW-1:0]  mismatch_count;
  logic                         over_limit;

  modport source (
    output valid, mismatch_count, over_limit,
    input  ready
  );

  modport sink (
    input  valid, mismatch_count, over_limit,
    output ready
  );
endinterface

// File: rtl/mnmc_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnmc_lane
// One compare lane: decode the read symbol, test it against the reference
// mask inside the lane range and register the mismatch bit.
// ----------------------------------------------------------------------------
module mnmc_lane (
  input  logic                           clk_i,
  input  logic                           load_i,
  input  logic [mnmc_pkg::LaneIdxW-1:0]  lane_id_i,
  input  logic [mnmc_pkg::LaneIdxW-1:0]  lane_lo_i,
  input  logic [mnmc_pkg::LaneIdxW-1:0]  lane_hi_i,
  input  logic [mnmc_pkg::MaskW-1:0]     mask_i,
  input  logic [mnmc_pkg::SymW-1:0]      sym_i,
  output logic                           miss_o
);
  import mnmc_pkg::*;

  logic in_range;
  logic miss_d, miss_q;

  assign in_range = (lane_id_i >= lane_lo_i) && (lane_id_i <= lane_hi_i);
  assign miss_d   = in_range && ((mask_i & read_code(sym_i)) == '0);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      miss_q <= miss_d;
    end
  end

  assign miss_o = miss_q;

endmodule

// File: rtl/mnmc_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnmc_merge
// Merge stage: count the lane mismatches, add them to the saturating
// running count, track the limit and hold the result for the sink.
// ----------------------------------------------------------------------------
module mnmc_merge (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mnmc_pkg::stage_ctrl_t        ctrl_i,
  input  logic [mnmc_pkg::LANES-1:0]   miss_i,
  input  logic [mnmc_pkg::CountW-1:0]  max_errors_i,
  output logic                         take_o,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output logic [mnmc_pkg::CountW-1:0]  mismatch_count_o,
  output logic                         over_limit_o
);
  import mnmc_pkg::*;

  logic [AddW-1:0]   added;
  logic [SumW-1:0]   sum;
  logic [CountW-1:0] base;
  logic              flag_base;
  logic [CountW-1:0] count_d, count_q;
  logic              flag_d, flag_q;
  logic              res_valid_d, res_valid_q;
  logic [CountW-1:0] res_count_q;
  logic              res_flag_q;

  always_comb begin
    added = '0;
    for (int unsigned l = 0; l < LANES; l++) begin
      added = added + AddW'(miss_i[l]);
    end
  end

  // A first word starts from a clear count and flag.
  assign base      = ctrl_i.first ? '0 : count_q;
  assign flag_base = ctrl_i.first ? 1'b0 : flag_q;
  assign sum       = SumW'(base) + SumW'(added);
  assign flag_d    = flag_base || (sum > SumW'(max_errors_i));
  assign count_d   = (sum > SumW'(CountMax)) ? CountMax : sum[CountW-1:0];

  // Words that end nothing always drain; a last word waits for a free slot.
  assign take_o = ctrl_i.valid && (!ctrl_i.last || !res_valid_q || res_ready_i);

  always_comb begin
    res_valid_d = res_valid_q;
    if (take_o && ctrl_i.last) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      flag_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (take_o) begin
        count_q <= count_d;
        flag_q  <= flag_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && ctrl_i.last) begin
      res_count_q <= count_d;
      res_flag_q  <= flag_d;
    end
  end

  assign res_valid_o      = res_valid_q;
  assign mismatch_count_o = res_count_q;
  assign over_limit_o     = res_flag_q;

endmodule

// File: rtl/masked_nucleotide_mismatch_count.sv
`timescale 1ns / 1ps
// A result is held in the merge stage's result register once its last word has passed
// the lane stage. Throughput: one word per cycle, unless a last word waits for the
// result register while the sink still holds the previous result.
// Reset clears the running count, the over-limit flag, max_errors and all
// valid flags; the block takes requests in the first cycle after reset.
// ----------------------------------------------------------------------------
// masked_nucleotide_mismatch_count
// Bounded Hamming distance between a read and a masked reference, eight
// bases per request, with an APB-style port for the mismatch limit.
// ----------------------------------------------------------------------------
module masked_nucleotide_mismatch_count (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  mnmc_req_if.sink                     req_i,
  mnmc_res_if.source                   res_o,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [mnmc_pkg::PaddrW-1:0]  paddr_i,
  input  logic [mnmc_pkg::PdataW-1:0]  pwdata_i,
  output logic [mnmc_pkg::PdataW-1:0]  prdata_o,
  output logic                         pready_o
);
  import mnmc_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration: one register, max_errors, at byte address 0. Bits [1:0]
  // of the address pick a byte within the word and are ignored.
  // --------------------------------------------------------------------------
  logic [CountW-1:0] max_errors_q;
  logic              hit_max_errors;
  logic              cfg_write;

  assign pready_o       = 1'b1;
  assign hit_max_errors = (paddr_i[PaddrW-1:2] == RegMaxErrors);
  assign cfg_write      = psel_i && penable_i && pwrite_i && pready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_errors_q <= '0;
    end else if (cfg_write && hit_max_errors) begin
      max_errors_q <= pwdata_i[CountW-1:0];
    end
  end

  // Unmapped addresses read as zero.
  assign prdata_o = hit_max_errors ? PdataW'(max_errors_q) : '0;

  // --------------------------------------------------------------------------
  // Lane stage: each lane compares one base and registers its mismatch bit.
  // The stage loads whenever it is empty or its contents move on this cycle,
  // so a new request enters while the previous one merges.
  // --------------------------------------------------------------------------
  stage_ctrl_t       ctrl_q;
  logic              take;
  logic              load;
  logic [LANES-1:0]  miss;

  assign load        = !ctrl_q.valid || take;
  assign req_i.ready = load;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    mnmc_lane u_lane (
      .clk_i     (clk_i),
      .load_i    (load),
      .lane_id_i (LaneIdxW'(l)),
      .lane_lo_i (req_i.lane_lo),
      .lane_hi_i (req_i.lane_hi),
      .mask_i    (req_i.ref_word[l*MaskW +: MaskW]),
      .sym_i     (req_i.seq_symbols[l*SymW +: SymW]),
      .miss_o    (miss[l])
    );
  end

  // Hold the start and end marks alongside the lane bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (load) begin
      ctrl_q.valid <= req_i.valid;
      ctrl_q.first <= req_i.first_word;
      ctrl_q.last  <= req_i.last_word;
    end
  end

  // --------------------------------------------------------------------------
  // Merge stage: sum the lanes, advance the running count and present the
  // result of a last word from its own register, so the lane stage keeps
  // flowing while a result waits for the sink, unless it holds another last word.
  // --------------------------------------------------------------------------
  mnmc_merge u_merge (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl_q),
    .miss_i           (miss),
    .max_errors_i     (max_errors_q),
    .take_o           (take),
    .res_valid_o      (res_o.valid),
    .res_ready_i      (res_o.ready),
    .mismatch_count_o (res_o.mismatch_count),
    .over_limit_o     (res_o.over_limit)
  );

endmodule
